// ----- rtl/core/vpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vpd_pkg
// shared types and constants of the vector pair distance block
// ----------------------------------------------------------------------------
package vpd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] MODE_MANHATTAN = 2'd0;
	localparam logic [1:0] MODE_BRAY      = 2'd1;
	localparam logic [1:0] MODE_JACCARD   = 2'd2;
	localparam logic [1:0] MODE_FISHER    = 2'd3;

	localparam logic [31:0] LN2_Q32      = 32'd2977044472;
	localparam logic [47:0] FISHER_EMPTY = 48'd4724314;
	localparam logic [24:0] LOG_BASE     = 25'h1000000;

	typedef struct packed {
		logic [16:0]        abs_diff;
		logic signed [16:0] pair_sum;
		logic               any_pos;
		logic               both_pos;
		logic [29:0]        product;
		logic               last;
	} item_t;

endpackage

// ----- rtl/core/vpd_ifs.sv -----
// ----------------------------------------------------------------------------
// vpd channel interfaces
// valid/ready channels for element pairs, results and the mode register
// ----------------------------------------------------------------------------
interface vpd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic               last_pair;
	modport source (output valid, x_value, y_value, last_pair, input ready);
	modport sink (input valid, x_value, y_value, last_pair, output ready);
endinterface

interface vpd_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] distance;
	logic               guard_hit;
	modport source (output valid, distance, guard_hit, input ready);
	modport sink (input valid, distance, guard_hit, output ready);
endinterface

interface vpd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] distance_mode;
	modport source (output valid, distance_mode, input ready);
	modport sink (input valid, distance_mode, output ready);
endinterface

// ----- rtl/core/vpd_front.sv -----
// ----------------------------------------------------------------------------
// vpd_front
// accepts element pairs and classifies them into queue entries
// ----------------------------------------------------------------------------
module vpd_front (
	vpd_in_if.sink         pair_in,
	input  logic           full,
	output logic           push,
	output vpd_pkg::item_t push_item
);

	logic signed [16:0] diff;
	logic               x_pos;
	logic               y_pos;

	always_comb begin
		x_pos = !pair_in.x_value[15] && (pair_in.x_value != 16'sd0);
		y_pos = !pair_in.y_value[15] && (pair_in.y_value != 16'sd0);
		diff  = 17'(pair_in.x_value) - 17'(pair_in.y_value);
		push_item.abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
		push_item.pair_sum = 17'(pair_in.x_value) + 17'(pair_in.y_value);
		push_item.any_pos  = x_pos || y_pos;
		push_item.both_pos = x_pos && y_pos;
		push_item.product  = (x_pos && y_pos) ?
			30'(pair_in.x_value[14:0] * pair_in.y_value[14:0]) : 30'd0;
		push_item.last     = pair_in.last_pair;
	end

	assign pair_in.ready = !full;
	assign push          = pair_in.valid && !full;

endmodule

// ----- rtl/core/vpd_queue.sv -----
// ----------------------------------------------------------------------------
// vpd_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
module vpd_queue #(
	parameter int DEPTH = vpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vpd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output vpd_pkg::item_t pop_item,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vpd_pkg::item_t    mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/vpd_back.sv -----
// ----------------------------------------------------------------------------
// vpd_back
// accumulates queued pairs and works out the distance on the last pair
// ----------------------------------------------------------------------------
module vpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  vpd_pkg::item_t pop_item,
	output logic           pop,
	vpd_cfg_if.sink        cfg,
	vpd_out_if.source      dist_out
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQRT  = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_FIN   = 4'd3;
	localparam logic [3:0] ST_NORM  = 4'd4;
	localparam logic [3:0] ST_LOG   = 4'd5;
	localparam logic [3:0] ST_SCALE = 4'd6;
	localparam logic [3:0] ST_RND   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [1:0]         mode_q;
	logic [3:0]         state_q;
	logic [5:0]         step_q;
	logic               last_q;

	logic [24:0]        abs_q;
	logic signed [25:0] tot_q;
	logic [8:0]         both_q;
	logic [8:0]         any_q;
	logic [31:0]        root_q;
	logic               ovf_q;

	logic [45:0]        sq_v_q;
	logic [45:0]        sq_res_q;
	logic [45:0]        sq_bit_q;

	logic [40:0]        num_q;
	logic [25:0]        den_q;
	logic [25:0]        rem_q;

	logic [31:0]        y_q;
	logic [4:0]         p_q;
	logic [24:0]        l_q;
	logic               neg_q;
	logic [56:0]        mprod_q;

	logic [47:0]        dist_q;
	logic               guard_q;
	logic               out_valid_q;
	logic [47:0]        out_dist_q;
	logic               out_guard_q;

	logic [25:0]        abs_sum;
	logic signed [26:0] tot_sum;
	logic [46:0]        sq_trial;
	logic [26:0]        div_trial;
	logic [63:0]        y_sq;
	logic [32:0]        y_next;
	logic [32:0]        root_sum;
	logic [24:0]        log_t;
	logic [57:0]        rnd_sum;
	logic [22:0]        mag;
	logic               out_free;

	assign cfg.ready          = 1'b1;
	assign dist_out.valid     = out_valid_q;
	assign dist_out.distance  = out_dist_q;
	assign dist_out.guard_hit = out_guard_q;
	assign out_free           = !out_valid_q || dist_out.ready;
	assign pop                = (state_q == ST_IDLE) && !empty;

	always_comb begin
		abs_sum   = {1'b0, abs_q} + 26'(pop_item.abs_diff);
		tot_sum   = 27'(tot_q) + 27'(pop_item.pair_sum);
		sq_trial  = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
		div_trial = {rem_q, num_q[40]};
		y_sq      = y_q * y_q;
		y_next    = y_sq[63:31];
		root_sum  = {1'b0, root_q} + 33'(sq_res_q[22:0]);
		log_t     = (l_q > vpd_pkg::LOG_BASE) ? l_q - vpd_pkg::LOG_BASE :
			vpd_pkg::LOG_BASE - l_q;
		rnd_sum   = {1'b0, mprod_q} + 58'h400000000;
		mag       = rnd_sum[57:35];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					last_q   <= pop_item.last;
					sq_v_q   <= {pop_item.product, 16'd0};
					sq_res_q <= '0;
					sq_bit_q <= 46'h1 << 44;
				end
			end
			ST_SQRT: begin
				if ({1'b0, sq_v_q} >= sq_trial) begin
					sq_v_q   <= sq_v_q - sq_trial[45:0];
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_FIN: begin
				guard_q <= 1'b0;
				dist_q  <= '0;
				rem_q   <= '0;
				y_q     <= root_q;
				p_q     <= 5'd31;
				case (mode_q)
					vpd_pkg::MODE_MANHATTAN: begin
						dist_q <= {15'd0, abs_q, 8'd0};
					end
					vpd_pkg::MODE_BRAY: begin
						guard_q <= (tot_q <= 26'sd0);
						num_q   <= {abs_q, 16'd0};
						den_q   <= {1'b0, tot_q[24:0]};
					end
					vpd_pkg::MODE_JACCARD: begin
						guard_q <= (any_q == 9'd0);
						num_q   <= {16'd0, any_q - both_q, 16'd0};
						den_q   <= {17'd0, any_q};
					end
					default: begin
						if (root_q == '0) begin
							guard_q <= 1'b1;
							dist_q  <= vpd_pkg::FISHER_EMPTY;
						end
					end
				endcase
			end
			ST_NORM: begin
				if (!y_q[31]) begin
					y_q <= y_q << 1;
					p_q <= p_q - 1'b1;
				end
				l_q <= {p_q, 20'd0};
			end
			ST_LOG: begin
				if (y_next[32]) begin
					l_q[5'd19 - step_q[4:0]] <= 1'b1;
					y_q <= y_next[32:1];
				end else begin
					y_q <= y_next[31:0];
				end
			end
			ST_SCALE: begin
				neg_q   <= (l_q > vpd_pkg::LOG_BASE);
				mprod_q <= log_t * vpd_pkg::LN2_Q32;
			end
			ST_RND: begin
				dist_q <= neg_q ? -48'(mag) : 48'(mag);
			end
			ST_DIV: begin
				if (div_trial >= {1'b0, den_q}) begin
					rem_q <= 26'(div_trial - {1'b0, den_q});
					num_q <= {num_q[39:0], 1'b1};
				end else begin
					rem_q <= div_trial[25:0];
					num_q <= {num_q[39:0], 1'b0};
				end
				if (step_q == 6'd40) begin
					dist_q <= 48'({num_q[39:0], div_trial >= {1'b0, den_q}});
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			out_dist_q  <= dist_q;
			out_guard_q <= guard_q || ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= vpd_pkg::MODE_MANHATTAN;
			state_q     <= ST_IDLE;
			step_q      <= '0;
			abs_q       <= '0;
			tot_q       <= '0;
			both_q      <= '0;
			any_q       <= '0;
			root_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.distance_mode;
			end
			if (dist_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (abs_sum[25]) begin
							abs_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							abs_q <= abs_sum[24:0];
						end
						if (tot_sum[26] != tot_sum[25]) begin
							tot_q <= tot_sum[26] ? {1'b1, 25'd0} : {1'b0, {25{1'b1}}};
							ovf_q <= 1'b1;
						end else begin
							tot_q <= tot_sum[25:0];
						end
						if (pop_item.any_pos) begin
							if (any_q == '1) begin
								ovf_q <= 1'b1;
							end else begin
								any_q <= any_q + 1'b1;
							end
						end
						if (pop_item.both_pos) begin
							if (both_q == '1) begin
								ovf_q <= 1'b1;
							end else begin
								both_q <= both_q + 1'b1;
							end
						end
						step_q <= '0;
						if (pop_item.both_pos) begin
							state_q <= ST_SQRT;
						end else if (pop_item.last) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd22) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (root_sum[32]) begin
						root_q <= '1;
						ovf_q  <= 1'b1;
					end else begin
						root_q <= root_sum[31:0];
					end
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					step_q <= '0;
					case (mode_q)
						vpd_pkg::MODE_MANHATTAN: state_q <= ST_OUT;
						vpd_pkg::MODE_BRAY: state_q <= (tot_q <= 26'sd0) ? ST_OUT : ST_DIV;
						vpd_pkg::MODE_JACCARD: state_q <= (any_q == 9'd0) ? ST_OUT : ST_DIV;
						default: state_q <= (root_q == '0) ? ST_OUT : ST_NORM;
					endcase
				end
				ST_NORM: begin
					if (y_q[31]) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd19) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_RND;
				ST_RND: state_q <= ST_OUT;
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd40) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						abs_q       <= '0;
						tot_q       <= '0;
						both_q      <= '0;
						any_q       <= '0;
						root_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/vector_pair_distance_top.sv -----
// ----------------------------------------------------------------------------
// vector_pair_distance_top
// manhattan, bray-curtis, jaccard and fisher distance of two streamed vectors
// ----------------------------------------------------------------------------
// channel   dir  payload                          transaction
// pair_in   in   x_value, y_value, last_pair      valid && ready
// dist_out  out  distance, guard_hit              valid && ready
// cfg       in   distance_mode                    valid && ready
//
// a pair is accumulated in the back part; when both elements are positive it
// also runs a bit serial square root, one result bit a cycle
// the last pair then runs the output step for manhattan, the divider for the
// divider modes and, for fisher, a mantissa shift and 20 squaring steps
// the queue lets the front take pairs while the back is busy or the result
// waits; control state and accumulators clear on reset, no clearing pass
// ----------------------------------------------------------------------------
module vector_pair_distance_top #(
	parameter int QUEUE_DEPTH = vpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vpd_in_if.sink    pair_in,
	vpd_out_if.source dist_out,
	vpd_cfg_if.sink   cfg
);

	vpd_pkg::item_t push_item;
	vpd_pkg::item_t pop_item;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	vpd_front u_front (
		.pair_in   (pair_in),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	vpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	vpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_item (pop_item),
		.pop      (pop),
		.cfg      (cfg),
		.dist_out (dist_out)
	);

endmodule

// ----- rtl/core/vpd_checker.sv -----
// ----------------------------------------------------------------------------
// vpd_checker
// port level checks of the vector pair distance block
// ----------------------------------------------------------------------------
module vpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [47:0] out_distance,
	input logic               out_guard,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_mode
);

	logic [1:0]  mode_q;
	logic [15:0] pending_q;
	logic        in_last_acc;
	logic        out_acc;

	assign in_last_acc = in_valid && in_ready && in_last;
	assign out_acc     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= vpd_pkg::MODE_MANHATTAN;
			pending_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_mode;
			end
			if (in_last_acc && !out_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_acc && !in_last_acc) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_guard))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 16'd0)
		else $error("result without a closing pair");

	a_jaccard_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == vpd_pkg::MODE_JACCARD |->
		out_distance >= 48'sd0 && out_distance <= 48'sd65536)
		else $error("jaccard distance out of range");

	a_manhattan_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == vpd_pkg::MODE_MANHATTAN |->
		out_distance[7:0] == 8'd0 && !out_distance[47])
		else $error("manhattan distance malformed");

endmodule

bind vector_pair_distance_top vpd_checker u_vpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pair_in.valid),
	.in_ready     (pair_in.ready),
	.in_last      (pair_in.last_pair),
	.out_valid    (dist_out.valid),
	.out_ready    (dist_out.ready),
	.out_distance (dist_out.distance),
	.out_guard    (dist_out.guard_hit),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready),
	.cfg_mode     (cfg.distance_mode)
);

// ----- tb/tb_vector_pair_distance_top.sv -----
// ----------------------------------------------------------------------------
// tb_vector_pair_distance_top
// Streams pairs of vectors through the block in all four distance modes.
// Each accepted pair updates an in-bench predictor. Every last pair queues
// the expected distance and guard flag, and results are checked in order.
// Directed vectors cover the extremes, every guard and accumulator
// saturation. They are followed by random vectors under random idling on
// both sides; one long output hold-off starts once 300 pairs are accepted.
// ----------------------------------------------------------------------------
module tb_vector_pair_distance_top;

	localparam int LIMIT = 2000000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} pair_t;

	typedef struct {
		logic signed [47:0] distance;
		logic               guard_hit;
	} dist_t;

	logic clk;
	logic arst_n;
	vpd_in_if  pin();
	vpd_out_if dout();
	vpd_cfg_if cfg_ch();

	vector_pair_distance_top uut (
		.clk(clk), .arst_n(arst_n), .pair_in(pin), .dist_out(dout), .cfg(cfg_ch)
	);

	// predictor state
	logic [1:0]         mode;
	logic [24:0]        abs_sum;
	logic signed [25:0] tot_sum;
	logic [8:0]         both_cnt;
	logic [8:0]         any_cnt;
	logic [31:0]        root_sum;
	logic               sat_flag;

	pair_t pair_q[$];
	dist_t dist_exp[$];
	pair_t cur;
	int    cyc = 0;
	int    errors = 0;
	int    pairs_sent = 0;
	int    dists_seen = 0;
	int    hold_left = 0;
	bit    hold_done = 0;
	bit    no_idle = 0;
	int    mode_hits[4] = '{0, 0, 0, 0};

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned log2_q20(longint unsigned r);
		int p = 0;
		longint unsigned m;
		longint unsigned l;
		while (p < 31 && (r >> (p + 1)) != 0) p++;
		m = r << (31 - p);
		l = longint'(p) << 20;
		for (int i = 0; i < 20; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				l = l | (64'd1 << (19 - i));
				m = m >> 1;
			end
		end
		return l;
	endfunction

	function automatic logic signed [47:0] fisher_dist(longint unsigned r);
		longint unsigned l = log2_q20(r);
		longint unsigned base = 64'd16 << 20;
		longint unsigned t;
		longint unsigned mag;
		t = (l > base) ? l - base : base - l;
		mag = (t * 2 * longint'(vpd_pkg::LN2_Q32) + (64'd1 << 35)) >> 36;
		return (l > base) ? -$signed(48'(mag)) : $signed(48'(mag));
	endfunction

	function automatic void clear_sums();
		abs_sum = '0; tot_sum = '0; both_cnt = '0; any_cnt = '0;
		root_sum = '0; sat_flag = 1'b0;
	endfunction

	// update the accumulators for one accepted pair, queue a result on the last
	function automatic void predict_pair(pair_t p);
		longint xv = p.x;
		longint yv = p.y;
		longint d = xv - yv;
		longint unsigned a;
		longint t;
		dist_t r;
		a = abs_sum + ((d < 0) ? -d : d);
		if (a > 64'h1FFFFFF) begin a = 64'h1FFFFFF; sat_flag = 1'b1; end
		abs_sum = a[24:0];
		t = tot_sum + xv + yv;
		if (t > 33554431) begin t = 33554431; sat_flag = 1'b1; end
		if (t < -33554432) begin t = -33554432; sat_flag = 1'b1; end
		tot_sum = t[25:0];
		if (xv > 0 || yv > 0) begin
			if (any_cnt < 511) any_cnt++;
			else sat_flag = 1'b1;
		end
		if (xv > 0 && yv > 0) begin
			if (both_cnt < 511) both_cnt++;
			else sat_flag = 1'b1;
			a = root_sum + int_sqrt(longint'(xv * yv) << 16);
			if (a > 64'hFFFFFFFF) begin a = 64'hFFFFFFFF; sat_flag = 1'b1; end
			root_sum = a[31:0];
		end
		if (!p.last) return;
		r.distance = '0;
		r.guard_hit = 1'b0;
		case (mode)
			vpd_pkg::MODE_MANHATTAN: begin
				r.distance = 48'(longint'(abs_sum) << 8);
			end
			vpd_pkg::MODE_BRAY: begin
				if (tot_sum <= 0) r.guard_hit = 1'b1;
				else r.distance = 48'((longint'(abs_sum) << 16) / longint'(tot_sum));
			end
			vpd_pkg::MODE_JACCARD: begin
				if (any_cnt == 0) r.guard_hit = 1'b1;
				else r.distance = 48'((longint'(any_cnt - both_cnt) << 16) / longint'(any_cnt));
			end
			default: begin
				if (root_sum == 0) begin
					r.guard_hit = 1'b1;
					r.distance = vpd_pkg::FISHER_EMPTY;
				end else begin
					r.distance = fisher_dist(root_sum);
				end
			end
		endcase
		r.guard_hit = r.guard_hit | sat_flag;
		mode_hits[mode]++;
		dist_exp.push_back(r);
		clear_sums();
	endfunction

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2: return 16'sd0;
			3: return 16'sd1;
			4: return -16'sd1;
			5, 6: return 16'($urandom_range(1, 400));
			7: return -16'($urandom_range(1, 400));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void push_pair(int x, int y, bit last);
		pair_t p;
		p.x = 16'(x); p.y = 16'(y); p.last = last;
		pair_q.push_back(p);
	endfunction

	function automatic void push_vector(int len);
		pair_t p;
		for (int i = 0; i < len; i++) begin
			p.x = pick_value(); p.y = pick_value(); p.last = (i == len - 1);
			pair_q.push_back(p);
		end
	endfunction

	function automatic bit idle_now();
		if (no_idle) return 1'b0;
		return $urandom_range(0, 99) < 22;
	endfunction

	// pair driver, predicts on every accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (pin.valid && pin.ready) begin
				cur.x = pin.x_value; cur.y = pin.y_value; cur.last = pin.last_pair;
				predict_pair(cur);
				pairs_sent++;
			end
			if (!pin.valid || pin.ready) begin
				if (pair_q.size() > 0 && !idle_now()) begin
					cur = pair_q.pop_front();
					pin.valid <= 1'b1;
					pin.x_value <= cur.x;
					pin.y_value <= cur.y;
					pin.last_pair <= cur.last;
				end else begin
					pin.valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, counted in cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && pairs_sent >= 300) begin
				hold_done <= 1'b1;
				hold_left <= 400;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				dists_seen++;
				if (dist_exp.size() == 0) begin
					$error("unexpected result distance=%0d", dout.distance);
					errors++;
				end else begin
					if (dout.distance !== dist_exp[0].distance) begin
						$error("distance expected %0d actual %0d",
							dist_exp[0].distance, dout.distance);
						errors++;
					end
					if (dout.guard_hit !== dist_exp[0].guard_hit) begin
						$error("guard_hit expected %0b actual %0b",
							dist_exp[0].guard_hit, dout.guard_hit);
						errors++;
					end
					void'(dist_exp.pop_front());
				end
			end
			if (hold_left > 0) begin
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= !idle_now();
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_mode(logic [1:0] m);
		cfg_ch.valid <= 1'b1;
		cfg_ch.distance_mode <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		mode = m;
	endtask

	task automatic drain();
		while (pair_q.size() != 0 || pin.valid || dist_exp.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		pin.valid = 1'b0; pin.x_value = '0; pin.y_value = '0; pin.last_pair = 1'b0;
		dout.ready = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.distance_mode = '0;
		mode = vpd_pkg::MODE_MANHATTAN;
		clear_sums();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// manhattan at reset mode, extremes and abs sum saturation
		push_pair(32767, -32768, 0);
		push_pair(-32768, 32767, 1);
		push_pair(0, 0, 1);
		for (int i = 0; i < 520; i++) push_pair(32767, -32768, i == 519);
		drain();

		// no idling on either side through the long saturation vectors
		no_idle = 1'b1;
		write_mode(vpd_pkg::MODE_BRAY);
		push_pair(0, 0, 1);
		push_pair(1, -5, 1);
		push_pair(100, 50, 0);
		push_pair(3, 7, 1);
		for (int i = 0; i < 520; i++) push_pair(32767, 32767, i == 519);
		for (int i = 0; i < 520; i++) push_pair(-32768, -32768, i == 519);
		drain();
		no_idle = 1'b0;

		write_mode(vpd_pkg::MODE_JACCARD);
		push_pair(-1, -1, 1);
		push_pair(5, 0, 0);
		push_pair(3, 4, 1);
		push_pair(0, 9, 1);
		drain();

		write_mode(vpd_pkg::MODE_FISHER);
		push_pair(-3, 2, 1);
		push_pair(1, 1, 1);
		push_pair(32767, 32767, 1);
		push_pair(256, 256, 1);
		push_pair(32767, 32767, 0);
		push_pair(32767, 32767, 1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_mode((ph < 4) ? 2'(3 - ph) : 2'($urandom_range(0, 3)));
			no_idle = (ph == 5);
			while (pair_q.size() < 20) begin
				if ($urandom_range(0, 19) == 0) push_vector($urandom_range(17, 64));
				else push_vector($urandom_range(1, 12));
			end
			drain();
		end
		no_idle = 1'b0;

		$display("pairs accepted: %0d, distances checked: %0d", pairs_sent, dists_seen);
		$display("per mode (manhattan/bray/jaccard/fisher): %0d %0d %0d %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
